### rtl/wsd_pkg.sv
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [3:0] OP_MASK   = 4'hF;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extension / key byte counts, stored minus one
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  // one classified request handed from parser to output stage
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       has_data;
    logic [3:0] opcode;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/wsd_front.sv
module wsd_front #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output wsd_pkg::entry_t push_entry
);

  wsd_pkg::phase_t          phase_r, phase_nxt;
  logic [3:0]               op_r, op_nxt;
  logic                     mask_r, mask_nxt;
  logic [LENGTH_BITS-1:0]   rem_r, rem_nxt;
  logic [2:0]               cnt_r, cnt_nxt;
  logic [31:0]              key_r, key_nxt;
  logic [1:0]               idx_r, idx_nxt;

  logic                     len_done;
  logic                     hdr_done;
  logic [4:0]               key_sh;
  logic [31:0]              key_shifted;

  // key byte 0 sits in the top byte
  assign key_sh      = {~idx_r, 3'b000};
  assign key_shifted = key_r >> key_sh;

  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    mask_nxt   = mask_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    push       = 1'b0;
    push_entry = '0;
    if (acc) begin
      case (phase_r)
        wsd_pkg::PH_HDR0: begin
          op_nxt    = rx_byte[3:0] & wsd_pkg::OP_MASK;
          phase_nxt = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          mask_nxt = rx_byte[7];
          rem_nxt  = '0;
          if (rx_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            cnt_nxt   = wsd_pkg::EXT16_CNT;
            phase_nxt = wsd_pkg::PH_EXT;
          end else if (rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            cnt_nxt   = wsd_pkg::EXT64_CNT;
            phase_nxt = wsd_pkg::PH_EXT;
          end else begin
            rem_nxt  = LENGTH_BITS'(rx_byte[6:0]);
            len_done = 1'b1;
          end
        end
        wsd_pkg::PH_EXT: begin
          // big-endian; bits above LENGTH_BITS fall off
          rem_nxt = {rem_r[LENGTH_BITS-9:0], rx_byte};
          if (cnt_r == 3'd0) begin
            len_done = 1'b1;
          end else begin
            cnt_nxt = cnt_r - 3'd1;
          end
        end
        wsd_pkg::PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (cnt_r == 3'd0) begin
            hdr_done = 1'b1;
          end else begin
            cnt_nxt = cnt_r - 3'd1;
          end
        end
        wsd_pkg::PH_DATA: begin
          idx_nxt             = idx_r + 2'd1;
          rem_nxt             = rem_r - LENGTH_BITS'(1);
          push                = 1'b1;
          push_entry.data     = rx_byte;
          push_entry.mask     = mask_r ? key_shifted[7:0] : 8'h00;
          push_entry.has_data = 1'b1;
          push_entry.opcode   = op_r;
          push_entry.last     = (rem_r == LENGTH_BITS'(1));
          if (rem_r == LENGTH_BITS'(1)) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      endcase

      if (len_done) begin
        if (mask_nxt) begin
          cnt_nxt   = wsd_pkg::KEY_CNT;
          key_nxt   = '0;
          phase_nxt = wsd_pkg::PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        idx_nxt = 2'd0;
        if (rem_nxt == '0) begin
          // empty frame: lone end marker
          push              = 1'b1;
          push_entry.opcode = op_r;
          push_entry.last   = 1'b1;
          phase_nxt         = wsd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsd_pkg::PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsd_pkg::PH_HDR0;
      op_r    <= '0;
      mask_r  <= 1'b0;
      rem_r   <= '0;
      cnt_r   <= '0;
      key_r   <= '0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !push_entry.has_data) |-> (push_entry.last && push_entry.data == 8'h00))
    else $error("empty-frame marker without last or with data");

  a_data_phase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsd_pkg::PH_DATA) |-> (rem_r != '0))
    else $error("payload phase with zero bytes left");

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> acc)
    else $error("request pushed without an accepted byte");

endmodule

### rtl/wsd_queue.sv
module wsd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wsd_pkg::entry_t    push_entry,
  input  logic               pop,
  output wsd_pkg::entry_t    head,
  output wsd_pkg::q_status_t status
);

  localparam int DEPTH = wsd_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  wsd_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;

  assign status.full  = (count_r == (PW+1)'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/wsd_back.sv
module wsd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wsd_pkg::entry_t    head,
  input  wsd_pkg::q_status_t status,
  output logic               pop,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_data_byte,
  output logic               out_has_data,
  output logic [3:0]         out_frame_opcode,
  output logic               out_is_binary,
  output logic               out_is_close,
  output logic               out_frame_last
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       has_r;
  logic [3:0] op_r;
  logic       bin_r;
  logic       close_r;
  logic       last_r;

  // refill the output register when empty or being drained
  assign pop       = !status.empty && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r  <= head.data ^ head.mask;
      has_r   <= head.has_data;
      op_r    <= head.opcode;
      bin_r   <= (head.opcode == wsd_pkg::OP_BINARY);
      close_r <= (head.opcode == wsd_pkg::OP_CLOSE);
      last_r  <= head.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_data_byte    = data_r;
  assign out_has_data     = has_r;
  assign out_frame_opcode = op_r;
  assign out_is_binary    = bin_r;
  assign out_is_close     = close_r;
  assign out_frame_last   = last_r;

  a_marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !has_r) |-> (last_r && data_r == 8'h00))
    else $error("marker result with data or without last");

  a_flags_match_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (bin_r == (op_r == wsd_pkg::OP_BINARY)
                 && close_r == (op_r == wsd_pkg::OP_CLOSE)))
    else $error("frame flags disagree with opcode");

  a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (valid_r && $stable(data_r)))
    else $error("pending result dropped or changed");

endmodule

### rtl/websocket_frame_deframer.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_ready    in_rx_byte[7:0]
// out_      out  out_valid / out_ready  out_data_byte, out_has_data, out_frame_opcode,
//                                       out_is_binary, out_is_close, out_frame_last
//
// One byte per cycle sustained while the request queue has room; the parser is
// combinational, so a payload result sits in the queue right after its byte is taken
// and out_valid rises once the output register is free to take it (queue write, then output register).
// Header, extension length and mask key bytes leave no result; an empty frame
// leaves a single end marker once its header is complete.
// Synchronous active-low reset puts the parser at the first header byte and
// empties the queue and output register.
// in_ready drops only while the request queue is full; out_ready low backs the
// queue up behind the output register.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_has_data,
  output logic [3:0] out_frame_opcode,
  output logic       out_is_binary,
  output logic       out_is_close,
  output logic       out_frame_last
);

  logic               in_acc;
  logic               q_push;
  wsd_pkg::entry_t    q_push_entry;
  logic               q_pop;
  wsd_pkg::entry_t    q_head;
  wsd_pkg::q_status_t q_status;

  // the parser may need a slot for any byte, so stall on a full queue
  assign in_ready = !q_status.full;
  assign in_acc   = in_valid && in_ready;

  // front: header parse, length count, mask byte select
  wsd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .rx_byte    (in_rx_byte),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // short request queue decoupling parser from result side
  wsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // back: unmask, flag decode, output register
  wsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .status           (q_status),
    .pop              (q_pop),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_data_byte    (out_data_byte),
    .out_has_data     (out_has_data),
    .out_frame_opcode (out_frame_opcode),
    .out_is_binary    (out_is_binary),
    .out_is_close     (out_is_close),
    .out_frame_last   (out_frame_last)
  );

endmodule
